// ----- rtl/patg_pkg.sv -----
package patg_pkg;

    // Hash constants of the 32-bit murmur mix and finalizer.
    localparam logic [31:0] SEED_RESET = 32'h11112222;
    localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2     = 32'h1b873593;
    localparam logic [31:0] MIX_ADD    = 32'he6546b64;
    localparam logic [31:0] FMIX_C1    = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2    = 32'hc2b2ae35;
    localparam logic [31:0] HASH_LEN   = 32'd12;
    localparam int unsigned NUM_BLOCKS = 3;

    // Block selectors: which 32-bit word of the hashed bytes a mix cell takes.
    localparam int unsigned BLK_ADDR_UPPER = 0;
    localparam int unsigned BLK_ADDR_LOWER = 1;
    localparam int unsigned BLK_SUFFIX     = 2;

    // Source port: base + index mod span. The quotient index / span is
    // estimated as (index * PORT_RECIP) >> PORT_RECIP_SHIFT, which is exact
    // or one low for any 20-bit index.
    localparam logic [15:0] PORT_BASE        = 16'd40000;
    localparam logic [15:0] PORT_SPAN        = 16'd20000;
    localparam logic [15:0] PORT_RECIP       = 16'd53687;
    localparam int unsigned PORT_RECIP_SHIFT = 30;
    localparam int unsigned INDEX_W          = 20;
    localparam int unsigned PROD_W           = INDEX_W + 16;
    localparam int unsigned QUOT_W           = PROD_W - PORT_RECIP_SHIFT;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [31:0] suffix_word;
        logic [15:0] port_rem;     // index minus estimated multiple of span
    } patg_side_t;

    typedef struct packed {
        logic [31:0] h;
        patg_side_t  side;
    } patg_flow_t;

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    // Hashed bytes 0..11 read as little-endian 32-bit blocks.
    function automatic logic [31:0] block_word(input patg_side_t side,
                                               input int unsigned sel);
        logic [31:0] w;
        case (sel)
            BLK_ADDR_UPPER: w = bswap32(side.addr_high[63:32]);
            BLK_ADDR_LOWER: w = bswap32(side.addr_high[31:0]);
            BLK_SUFFIX:     w = side.suffix_word;
            default:        w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/patg_mix_cell.sv -----
module patg_mix_cell
    import patg_pkg::*;
#(
    parameter int unsigned BLOCK_SEL = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  patg_flow_t in_flow,
    output logic       out_valid,
    input  logic       out_ready,
    output patg_flow_t out_flow
);

    logic        s0_valid_reg, s1_valid_reg, s2_valid_reg;
    patg_flow_t  s0_flow_reg, s1_flow_reg, s2_flow_reg;
    logic [31:0] s0_k_reg, s1_k_reg;
    logic        s0_ready, s1_ready, s2_ready;
    logic [31:0] s0_k_next, s1_k_next, s2_h_next, h_rot;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    // k *= c1; k = rotl(k, 15) * c2; h = rotl(h ^ k, 13) * 5 + add
    assign s0_k_next = mul32(block_word(in_flow.side, BLOCK_SEL), MIX_C1);
    assign s1_k_next = mul32(rotl32(s0_k_reg, 15), MIX_C2);
    assign h_rot     = rotl32(s1_flow_reg.h ^ s1_k_reg, 13);
    assign s2_h_next = (h_rot << 2) + h_rot + MIX_ADD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s0_ready) s0_valid_reg <= in_valid;
            if (s1_ready) s1_valid_reg <= s0_valid_reg;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_ready && in_valid) begin
            s0_flow_reg <= in_flow;
            s0_k_reg    <= s0_k_next;
        end
        if (s1_ready && s0_valid_reg) begin
            s1_flow_reg <= s0_flow_reg;
            s1_k_reg    <= s1_k_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_flow_reg.h    <= s2_h_next;
            s2_flow_reg.side <= s1_flow_reg.side;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_flow  = s2_flow_reg;

endmodule

// ----- rtl/patg_fmix.sv -----
module patg_fmix
    import patg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  patg_flow_t in_flow,
    output logic       out_valid,
    input  logic       out_ready,
    output patg_flow_t out_flow
);

    logic        f0_valid_reg, f1_valid_reg;
    patg_flow_t  f0_flow_reg, f1_flow_reg;
    logic        f0_ready, f1_ready;
    logic [31:0] len_mix, f0_pre, f0_h_next, f1_pre, f1_h_next;

    assign f1_ready = !f1_valid_reg || out_ready;
    assign f0_ready = !f0_valid_reg || f1_ready;
    assign in_ready = f0_ready;

    // Fold in the length, then the first two xor-shift-multiply rounds.
    // The last xor-shift is left to the output stage.
    assign len_mix   = in_flow.h ^ HASH_LEN;
    assign f0_pre    = len_mix ^ (len_mix >> 16);
    assign f0_h_next = mul32(f0_pre, FMIX_C1);
    assign f1_pre    = f0_flow_reg.h ^ (f0_flow_reg.h >> 13);
    assign f1_h_next = mul32(f1_pre, FMIX_C2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else begin
            if (f0_ready) f0_valid_reg <= in_valid;
            if (f1_ready) f1_valid_reg <= f0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f0_ready && in_valid) begin
            f0_flow_reg.h    <= f0_h_next;
            f0_flow_reg.side <= in_flow.side;
        end
        if (f1_ready && f0_valid_reg) begin
            f1_flow_reg.h    <= f1_h_next;
            f1_flow_reg.side <= f0_flow_reg.side;
        end
    end

    assign out_valid = f1_valid_reg;
    assign out_flow  = f1_flow_reg;

endmodule

// ----- rtl/probe_address_tag_generator_core.sv -----
// Probe address tag generator: turns one request (prefix base, suffix mask,
// two random words, target index) into one IPv6 probe target and UDP source
// port. The upper address half is base + (mask & random_prefix) mod 2^64; the
// lower half is the byte-swapped random_suffix followed by a 32-bit murmur
// tag over address bytes 0..11, seeded by the hash_seed register; the user
// must write it through cfg_we/cfg_wdata only while no request is in flight,
// which the block does not enforce. The source port is 40000 + index mod
// 20000. A new request is taken every cycle while there is room; each passes
// two front stages (prefix add and port quotient, then port remainder), a row
// of three mix cells of three stages each, one per hashed 32-bit block, two
// finalizer stages, and the output register. Every stage has its own valid
// bit and hands off to its neighbor as soon as that neighbor is free, so
// empty stages keep filling while a finished result waits on m_tready.
module probe_address_tag_generator_core
    import patg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,     // hash_seed
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] prefix_base, [127:64] suffix_mask, [159:128] random_prefix,
    // [191:160] random_suffix, [211:192] probe_index, [215:212] zero
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] address_high, [127:64] address_low, [143:128] source_port
    output logic [143:0] m_tdata
);

    localparam logic [16:0] REM_LIMIT = {1'b0, PORT_SPAN} + {1'b0, PORT_SPAN};

    // Seed register.
    logic [31:0] hash_seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_seed_reg <= SEED_RESET;
        end else if (cfg_we) begin
            hash_seed_reg <= cfg_wdata;
        end
    end

    // Request fields.
    logic [63:0]        prefix_base, suffix_mask;
    logic [31:0]        random_prefix, random_suffix;
    logic [INDEX_W-1:0] probe_index;

    assign prefix_base   = s_tdata[63:0];
    assign suffix_mask   = s_tdata[127:64];
    assign random_prefix = s_tdata[159:128];
    assign random_suffix = s_tdata[191:160];
    assign probe_index   = s_tdata[211:192];

    // Front stage 1: prefix sum and port quotient estimate.
    logic               f1_valid_reg;
    logic [63:0]        f1_high_reg;
    logic [31:0]        f1_suffix_reg;
    logic [INDEX_W-1:0] f1_index_reg;
    logic [QUOT_W-1:0]  f1_quot_reg;
    logic [63:0]        f1_high_next;
    logic [PROD_W-1:0]  quot_prod;
    logic               f1_ready;

    assign f1_high_next = prefix_base + (suffix_mask & {32'd0, random_prefix});
    assign quot_prod    = {16'd0, probe_index} * {{INDEX_W{1'b0}}, PORT_RECIP};

    // Front stage 2: remainder, below twice the span; seed enters the hash.
    logic               f2_valid_reg;
    patg_flow_t         f2_flow_reg;
    logic [INDEX_W-1:0] rem_wide;
    logic               f2_ready;

    assign rem_wide = f1_index_reg -
                      ({{(INDEX_W-QUOT_W){1'b0}}, f1_quot_reg} *
                       {{(INDEX_W-16){1'b0}}, PORT_SPAN});

    // Cell row: one mix cell per hashed block.
    logic       chain_valid [NUM_BLOCKS+1];
    logic       chain_ready [NUM_BLOCKS+1];
    patg_flow_t chain_flow  [NUM_BLOCKS+1];

    assign f1_ready = !f1_valid_reg || f2_ready;
    assign f2_ready = !f2_valid_reg || chain_ready[0];
    assign s_tready = f1_ready;

    assign chain_valid[0] = f2_valid_reg;
    assign chain_flow[0]  = f2_flow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            if (f1_ready) f1_valid_reg <= s_tvalid;
            if (f2_ready) f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_ready && s_tvalid) begin
            f1_high_reg   <= f1_high_next;
            f1_suffix_reg <= random_suffix;
            f1_index_reg  <= probe_index;
            f1_quot_reg   <= quot_prod[PROD_W-1:PORT_RECIP_SHIFT];
        end
        if (f2_ready && f1_valid_reg) begin
            f2_flow_reg.h                <= hash_seed_reg;
            f2_flow_reg.side.addr_high   <= f1_high_reg;
            f2_flow_reg.side.suffix_word <= f1_suffix_reg;
            f2_flow_reg.side.port_rem    <= rem_wide[15:0];
        end
    end

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        patg_mix_cell #(
            .BLOCK_SEL(g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_flow   (chain_flow[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_flow  (chain_flow[g+1])
        );
    end

    // Finalizer.
    logic       fm_valid;
    patg_flow_t fm_flow;
    logic       out_ready_int;

    patg_fmix u_fmix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[NUM_BLOCKS]),
        .in_ready  (chain_ready[NUM_BLOCKS]),
        .in_flow   (chain_flow[NUM_BLOCKS]),
        .out_valid (fm_valid),
        .out_ready (out_ready_int),
        .out_flow  (fm_flow)
    );

    // Output register: last xor-shift, correct the port remainder, pack.
    logic        out_valid_reg;
    logic [63:0] out_high_reg, out_low_reg;
    logic [15:0] out_port_reg;
    logic [31:0] tag_next;
    logic [15:0] port_next;

    assign out_ready_int = !out_valid_reg || m_tready;
    assign tag_next      = fm_flow.h ^ (fm_flow.h >> 16);
    // Remainder one span too large means the quotient estimate was one low.
    assign port_next     = (fm_flow.side.port_rem >= PORT_SPAN)
                         ? fm_flow.side.port_rem + PORT_SPAN
                         : fm_flow.side.port_rem + PORT_BASE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready_int) begin
            out_valid_reg <= fm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready_int && fm_valid) begin
            out_high_reg <= fm_flow.side.addr_high;
            out_low_reg  <= {bswap32(fm_flow.side.suffix_word), tag_next};
            out_port_reg <= port_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_port_reg, out_low_reg, out_high_reg};

    // Checks.
    a_port_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[143:128] >= PORT_BASE) &&
                     (m_tdata[143:128] < PORT_BASE + PORT_SPAN))
        else $error("source port out of range");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        f2_valid_reg |-> ({1'b0, f2_flow_reg.side.port_rem} < REM_LIMIT))
        else $error("port quotient estimate off by more than one");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

endmodule
